// ----- sv/ptat_pkg.sv -----
package ptat_pkg;

	// Default geometry
	localparam int unsigned PAGE_WORDS_DEF = 512;
	localparam int unsigned MEM_WORDS_DEF  = 16384;

	// Field widths
	localparam int ADDR_W    = 14;
	localparam int DATA_W    = 16;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam int FRAME_W   = 5;
	localparam int OFFSET_W  = 9;
	localparam int STATUS_W  = 2;

	// Item operations
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_WRITE     = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FAULT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_USER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PT_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PT_LENGTH  = 2'd2;

	// Flag word bits
	localparam int FLAG_REF_BIT   = 0;
	localparam int FLAG_VALID_BIT = 1;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} ptat_in_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame_number;
		logic [OFFSET_W-1:0] word_offset;
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  fault_vpn;
	} ptat_out_t;

endpackage

// ----- sv/page_table_address_translator.sv -----
// Single-level page-table address translator with its own word memory. Each
// input transfer is either a memory word write or a translation, and each
// gives exactly one result transfer. Memory is split into an even-word and an
// odd-word bank, so the two words of a table entry (frame, then flags) are
// always read in the same cycle. Write items and kernel-mode translations
// give their result in the accept cycle; a user translation that reaches
// the table reads both entry words in the accept cycle, then in the next
// cycle checks them and, if both pass, writes the referenced bit back into
// the flag bank, with input stall high. A two-deep result queue (output
// register plus hold register) lets a new item in while a finished result
// still waits. Memory content is undefined after reset; no clearing pass.
// The user must write configuration via cfg_we/cfg_index/cfg_data only while
// no item is in flight (not enforced). PAGE_WORDS must be a power of two.
module page_table_address_translator
	import ptat_pkg::*;
#(
	parameter int unsigned PAGE_WORDS = PAGE_WORDS_DEF,
	parameter int unsigned MEM_WORDS  = MEM_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  ptat_in_t             in_data,

	output logic                 out_valid,
	input  logic                 out_stall,
	output ptat_out_t            out_data
);

	// internal address math width: covers length * PAGE_WORDS and base + 2*page + 1
	localparam int WW = 18;
	localparam int PB = $clog2(PAGE_WORDS);
	localparam int AW = $clog2(MEM_WORDS);
	localparam int BW = AW - 1;
	localparam int unsigned BANK_DEPTH = (MEM_WORDS + 1) / 2;
	localparam int unsigned FRAMES = MEM_WORDS / PAGE_WORDS;
	localparam int unsigned FRAME_LIMIT = (FRAMES < 32) ? FRAMES : 32;
	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_WORDS - 1);

	// configuration
	logic              user_mode_q;
	logic [CFG_W-1:0]  pt_base_q;
	logic [5:0]        pt_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_mode_q <= 1'b0;
			pt_base_q   <= '0;
			pt_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USER_MODE: user_mode_q <= cfg_data[0];
				CFG_PT_BASE:   pt_base_q   <= cfg_data;
				CFG_PT_LENGTH: pt_length_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// handshake state
	logic      busy_s1;     // lookup cycle of a user translation
	logic      hold_valid_q;
	ptat_out_t hold_q;
	logic      out_valid_q;
	ptat_out_t out_q;

	logic in_fire;
	assign in_stall = busy_s1 | hold_valid_q;
	assign in_fire  = in_valid & ~in_stall;

	// accept-cycle decode
	logic [ADDR_W-1:0] page;
	logic [ADDR_W-1:0] offset;
	logic [WW-1:0]     addr_w;
	logic [WW-1:0]     limit_w;
	logic [WW-1:0]     entry_w;
	logic [WW-1:0]     entry_hi_w;
	logic              addr_oob;
	logic              user_oob;
	logic              entry_oob;
	logic              kernel_oob;

	assign page       = in_data.address >> PB;
	assign offset     = in_data.address & PAGE_MASK;
	assign addr_w     = WW'(in_data.address);
	assign limit_w    = WW'(pt_length_q) << PB;
	assign entry_w    = WW'(pt_base_q) + WW'({page, 1'b0});
	assign entry_hi_w = entry_w + WW'(1);
	assign addr_oob   = addr_w >= WW'(MEM_WORDS);
	assign user_oob   = addr_w >= limit_w;
	assign entry_oob  = entry_hi_w >= WW'(MEM_WORDS);
	assign kernel_oob = page >= ADDR_W'(FRAME_LIMIT);

	logic start_lookup;
	assign start_lookup = in_fire && in_data.operation == OP_TRANSLATE && user_mode_q
		&& !addr_oob && !user_oob && !entry_oob;

	// lookup stage registers
	logic              odd_s1;    // entry starts in the odd bank
	logic [BW-1:0]     idx0_s1;
	logic [BW-1:0]     idx1_s1;
	logic [FRAME_W-1:0] page_s1;
	logic [OFFSET_W-1:0] offset_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= start_lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (start_lookup) begin
			odd_s1    <= entry_w[0];
			idx0_s1   <= entry_hi_w[AW-1:1];
			idx1_s1   <= entry_w[AW-1:1];
			page_s1   <= page[FRAME_W-1:0];
			offset_s1 <= offset[OFFSET_W-1:0];
		end
	end

	// banks: bank0 holds even words, bank1 odd words
	logic              b0_en, b0_we, b1_en, b1_we;
	logic [BW-1:0]     b0_idx, b1_idx;
	logic [DATA_W-1:0] b0_wdata, b1_wdata, b0_rdata, b1_rdata;

	logic [DATA_W-1:0] flags, frame;
	logic              flag_ok, frame_ok;

	assign flags    = odd_s1 ? b0_rdata : b1_rdata;
	assign frame    = odd_s1 ? b1_rdata : b0_rdata;
	assign flag_ok  = flags[FLAG_VALID_BIT];
	assign frame_ok = frame < DATA_W'(FRAME_LIMIT);

	logic [DATA_W-1:0] flags_set;
	always_comb begin
		flags_set = flags;
		flags_set[FLAG_REF_BIT] = 1'b1;
	end

	logic wr_item;
	assign wr_item = in_fire && in_data.operation == OP_WRITE && !addr_oob;

	always_comb begin
		b0_en    = 1'b0;
		b0_we    = 1'b0;
		b0_idx   = idx0_s1;
		b0_wdata = flags_set;
		b1_en    = 1'b0;
		b1_we    = 1'b0;
		b1_idx   = idx1_s1;
		b1_wdata = flags_set;
		priority if (busy_s1) begin
			// referenced-bit write-back into the flag bank
			if (flag_ok && frame_ok) begin
				b0_en = odd_s1;
				b0_we = odd_s1;
				b1_en = ~odd_s1;
				b1_we = ~odd_s1;
			end
		end else if (wr_item) begin
			b0_en    = ~addr_w[0];
			b0_we    = 1'b1;
			b0_idx   = addr_w[AW-1:1];
			b0_wdata = in_data.write_data;
			b1_en    = addr_w[0];
			b1_we    = 1'b1;
			b1_idx   = addr_w[AW-1:1];
			b1_wdata = in_data.write_data;
		end else if (start_lookup) begin
			b0_en  = 1'b1;
			b0_idx = entry_hi_w[AW-1:1];
			b1_en  = 1'b1;
			b1_idx = entry_w[AW-1:1];
		end else begin
			// idle: both banks off
		end
	end

	ptat_bank #(.DEPTH(BANK_DEPTH), .IDX_W(BW)) u_bank0 (
		.clk   (clk),
		.en    (b0_en),
		.we    (b0_we),
		.idx   (b0_idx),
		.wdata (b0_wdata),
		.rdata (b0_rdata)
	);

	ptat_bank #(.DEPTH(BANK_DEPTH), .IDX_W(BW)) u_bank1 (
		.clk   (clk),
		.en    (b1_en),
		.we    (b1_we),
		.idx   (b1_idx),
		.wdata (b1_wdata),
		.rdata (b1_rdata)
	);

	// result of this cycle, if any
	logic      res_valid;
	ptat_out_t res;

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		priority if (busy_s1) begin
			res_valid = 1'b1;
			priority if (!flag_ok) begin
				res.status    = STATUS_FAULT;
				res.fault_vpn = page_s1;
			end else if (!frame_ok) begin
				res.status = STATUS_ILLEGAL;
			end else begin
				res.status       = STATUS_OK;
				res.frame_number = frame[FRAME_W-1:0];
				res.word_offset  = offset_s1;
			end
		end else if (in_fire && !start_lookup) begin
			// writes, kernel translations and early user rejects finish at once
			res_valid = 1'b1;
			priority if (addr_oob) begin
				res.status = STATUS_ILLEGAL;
			end else if (in_data.operation == OP_WRITE) begin
				res.status = STATUS_OK;
			end else if (user_mode_q || kernel_oob) begin
				res.status = STATUS_ILLEGAL;
			end else begin
				res.status       = STATUS_OK;
				res.frame_number = page[FRAME_W-1:0];
				res.word_offset  = offset[OFFSET_W-1:0];
			end
		end else begin
			// no result this cycle
		end
	end

	// result queue: out register, hold register behind it
	logic out_free;
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= hold_valid_q | res_valid;
			hold_valid_q <= 1'b0;
		end else if (res_valid) begin
			hold_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				out_q <= hold_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			hold_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("hold register full while output register empty");

	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(hold_valid_q && res_valid))
		else $error("result produced while hold register full");

	a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> !busy_s1)
		else $error("lookup stage held longer than one cycle");

	a_single_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({b0_en && b0_we, b1_en && b1_we}))
		else $error("both banks written in one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_FAULT
			|| out_data.status == STATUS_ILLEGAL))
		else $error("undefined status code on output");
`endif

endmodule

// ----- sv/ptat_bank.sv -----
module ptat_bank
	import ptat_pkg::*;
#(
	parameter int unsigned DEPTH = MEM_WORDS_DEF / 2,
	parameter int IDX_W = $clog2(MEM_WORDS_DEF / 2)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[idx] <= wdata;
			end else begin
				rdata <= mem[idx];
			end
		end
	end

endmodule
